### src/ubbp_pkg.sv
// Shared types and constants for the USB bulk byte pipe packetizer.
// No dependencies; core, datapath and controller refer to it by scoped names, the bench imports it.
`timescale 1ns / 1ps

package ubbp_pkg;

   localparam int TX_DEPTH_DEF     = 2048;
   localparam int RX_DEPTH_DEF     = 256;
   localparam int PACKET_BYTES_DEF = 64;

   // function codes of a request
   localparam logic [2:0] FUNC_PUT       = 3'd0;
   localparam logic [2:0] FUNC_GET       = 3'd1;
   localparam logic [2:0] FUNC_HOST_BYTE = 3'd2;
   localparam logic [2:0] FUNC_IN_DONE   = 3'd3;
   localparam logic [2:0] FUNC_BUS_RESET = 3'd4;
   localparam logic [2:0] FUNC_SET_CFG   = 3'd5;
   localparam logic [2:0] FUNC_POLL      = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_GET  = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_ZLP  = 2'd2;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] byte_value;
      logic       config_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        got_byte;
      logic        last_in_packet;
      logic [31:0] dropped_count;
      logic [31:0] reset_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic tx_write;
      logic drop_inc;
      logic rx_write;
      logic rx_read;
      logic emit_get;
      logic get_hit;
      logic clr_flight;
      logic bus_reset;
      logic set_cfg;
      logic tx_read;
      logic emit_byte;
      logic emit_zlp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] func;
      logic       tx_full;
      logic       tx_empty;
      logic       rx_full;
      logic       rx_empty;
      logic       link_cfg;
      logic       in_flight;
      logic       zlp_owed;
      logic       pkt_last;
      logic       out_free;
   } stat_type;

endpackage

### src/usb_bulk_byte_pipe_packetizer_core.sv
// Top level of the USB bulk byte pipe packetizer: controller plus datapath.
// Depends on ubbp_pkg, ubbp_ctrl, ubbp_datapath (which holds two ubbp_ram).
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (ubbp_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (ubbp_pkg::rsp_type)
//
// One request at a time. A queued put, a host byte and control requests pass from exec to
// pump; an ignored or dropped put, an unused code and an empty get end in exec, a hit get
// in the get state. For a packet, the pump state issues the first transmit RAM
// read, then one byte per transfer, prefetched from the RAM's registered read port.
// Reset is synchronous; the rings start empty through their pointers, no sweep.
// A stalled rsp holds the result register and the controller waits on it;
// req stays ready only while the controller is idle.
`timescale 1ns / 1ps

module usb_bulk_byte_pipe_packetizer_core #(
   parameter int TX_DEPTH     = ubbp_pkg::TX_DEPTH_DEF,
   parameter int RX_DEPTH     = ubbp_pkg::RX_DEPTH_DEF,
   parameter int PACKET_BYTES = ubbp_pkg::PACKET_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ubbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ubbp_pkg::rsp_type rsp_data
);

   ubbp_pkg::cmd_type  cmd;
   ubbp_pkg::stat_type stat;

   ubbp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   ubbp_datapath #(
      .TX_DEPTH    (TX_DEPTH),
      .RX_DEPTH    (RX_DEPTH),
      .PACKET_BYTES(PACKET_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

### src/ubbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ubbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ubbp_datapath.sv
// Datapath: ring pointers, both ring memories, link flags, counters and the
// result register. Depends on ubbp_pkg and ubbp_ram; driven by ubbp_ctrl.
`timescale 1ns / 1ps

module ubbp_datapath #(
   parameter int TX_DEPTH     = ubbp_pkg::TX_DEPTH_DEF,
   parameter int RX_DEPTH     = ubbp_pkg::RX_DEPTH_DEF,
   parameter int PACKET_BYTES = ubbp_pkg::PACKET_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ubbp_pkg::req_type  req_data,
   input  ubbp_pkg::cmd_type  cmd,
   output ubbp_pkg::stat_type stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output ubbp_pkg::rsp_type  rsp_data
);

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int PKT_CW = $clog2(PACKET_BYTES);
   localparam logic [TX_AW-1:0]  TX_LAST  = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_AW-1:0]  RX_LAST  = RX_AW'(RX_DEPTH - 1);
   localparam logic [PKT_CW-1:0] PKT_LAST = PKT_CW'(PACKET_BYTES - 1);

   ubbp_pkg::req_type req_ff;
   ubbp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TX_AW-1:0]  tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RX_AW-1:0]  rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0]  tx_head_inc, tx_tail_inc;
   logic [RX_AW-1:0]  rx_head_inc, rx_tail_inc;
   logic [PKT_CW-1:0] pkt_cnt_ff, pkt_cnt_in;
   logic              in_flight_ff, in_flight_in;
   logic              zlp_owed_ff, zlp_owed_in;
   logic              link_cfg_ff, link_cfg_in;
   logic [31:0]       drop_cnt_ff, drop_cnt_in;
   logic [31:0]       reset_cnt_ff, reset_cnt_in;

   logic [7:0]        tx_rd_data, rx_rd_data;
   logic              tx_rd_en;
   logic [TX_AW-1:0]  tx_rd_addr;
   logic              out_free, pkt_last, out_load;

   assign tx_head_inc = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_inc = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
   assign rx_head_inc = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_inc = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pkt_last = (pkt_cnt_ff == PKT_LAST) || (tx_tail_inc == tx_head_ff);
   assign out_load = cmd.emit_get || cmd.emit_byte || cmd.emit_zlp;

   // fetch the first byte of a packet, then prefetch the next one per transfer
   assign tx_rd_en   = cmd.tx_read || (cmd.emit_byte && !pkt_last);
   assign tx_rd_addr = cmd.emit_byte ? tx_tail_inc : tx_tail_ff;

   ubbp_ram #(
      .WIDTH(8),
      .DEPTH(TX_DEPTH)
   ) u_tx_ram (
      .clock  (clock),
      .wr_en  (cmd.tx_write),
      .wr_addr(tx_head_ff),
      .wr_data(req_ff.byte_value),
      .rd_en  (tx_rd_en),
      .rd_addr(tx_rd_addr),
      .rd_data(tx_rd_data)
   );

   ubbp_ram #(
      .WIDTH(8),
      .DEPTH(RX_DEPTH)
   ) u_rx_ram (
      .clock  (clock),
      .wr_en  (cmd.rx_write),
      .wr_addr(rx_head_ff),
      .wr_data(req_ff.byte_value),
      .rd_en  (cmd.rx_read),
      .rd_addr(rx_tail_ff),
      .rd_data(rx_rd_data)
   );

   always_comb begin
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      in_flight_in = in_flight_ff;
      zlp_owed_in  = zlp_owed_ff;
      link_cfg_in  = link_cfg_ff;
      drop_cnt_in  = drop_cnt_ff;
      reset_cnt_in = reset_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (cmd.tx_write) begin
         tx_head_in = tx_head_inc;
      end
      if (cmd.drop_inc) begin
         drop_cnt_in = drop_cnt_ff + 32'd1;
      end
      if (cmd.rx_write) begin
         rx_head_in = rx_head_inc;
      end
      if (cmd.clr_flight) begin
         in_flight_in = 1'b0;
      end
      if (cmd.set_cfg) begin
         link_cfg_in = req_ff.config_flag;
      end
      if (cmd.bus_reset) begin
         reset_cnt_in = reset_cnt_ff + 32'd1;
         link_cfg_in  = 1'b0;
         in_flight_in = 1'b0;
         zlp_owed_in  = 1'b0;
         tx_head_in   = '0;
         tx_tail_in   = '0;
         rx_head_in   = '0;
         rx_tail_in   = '0;
      end
      if (cmd.tx_read) begin
         pkt_cnt_in = '0;
      end

      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.dropped_count  = drop_cnt_ff;
         rsp_in.reset_count    = reset_cnt_ff;
         rsp_in.got_byte       = 1'b0;
         rsp_in.last_in_packet = 1'b0;
         rsp_in.data_byte      = 8'd0;
      end
      if (cmd.emit_get) begin
         rsp_in.kind = ubbp_pkg::KIND_GET;
         if (cmd.get_hit) begin
            rsp_in.data_byte = rx_rd_data;
            rsp_in.got_byte  = 1'b1;
            rx_tail_in       = rx_tail_inc;
         end
      end
      if (cmd.emit_byte) begin
         rsp_in.kind           = ubbp_pkg::KIND_BYTE;
         rsp_in.data_byte      = tx_rd_data;
         rsp_in.last_in_packet = pkt_last;
         tx_tail_in            = tx_tail_inc;
         pkt_cnt_in            = pkt_cnt_ff + 1'b1;
         if (pkt_last) begin
            in_flight_in = 1'b1;
            // a full-size packet needs a ZLP to close the transfer
            zlp_owed_in  = (pkt_cnt_ff == PKT_LAST);
         end
      end
      if (cmd.emit_zlp) begin
         rsp_in.kind           = ubbp_pkg::KIND_ZLP;
         rsp_in.last_in_packet = 1'b1;
         zlp_owed_in           = 1'b0;
         in_flight_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         pkt_cnt_ff   <= '0;
         in_flight_ff <= 1'b0;
         zlp_owed_ff  <= 1'b0;
         link_cfg_ff  <= 1'b0;
         drop_cnt_ff  <= '0;
         reset_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         in_flight_ff <= in_flight_in;
         zlp_owed_ff  <= zlp_owed_in;
         link_cfg_ff  <= link_cfg_in;
         drop_cnt_ff  <= drop_cnt_in;
         reset_cnt_ff <= reset_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   assign stat.func      = req_ff.func;
   assign stat.tx_full   = (tx_head_inc == tx_tail_ff);
   assign stat.tx_empty  = (tx_head_ff == tx_tail_ff);
   assign stat.rx_full   = (rx_head_inc == rx_tail_ff);
   assign stat.rx_empty  = (rx_head_ff == rx_tail_ff);
   assign stat.link_cfg  = link_cfg_ff;
   assign stat.in_flight = in_flight_ff;
   assign stat.zlp_owed  = zlp_owed_ff;
   assign stat.pkt_last  = pkt_last;
   assign stat.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register loaded while holding an untaken result");

   a_tx_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.tx_write |-> (tx_head_inc != tx_tail_ff))
      else $error("transmit ring written while full");

   a_last_sets_flight: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_byte && pkt_last) |=> in_flight_ff)
      else $error("packet closed without marking IN in flight");

endmodule

### src/ubbp_ctrl.sv
// Controller: sequences one request at a time, then the packet pump.
// Depends on ubbp_pkg; commands ubbp_datapath.
`timescale 1ns / 1ps

module ubbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ubbp_pkg::stat_type stat,
   output ubbp_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GET,
      ST_PUMP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (stat.func)
               ubbp_pkg::FUNC_PUT: begin
                  if (!stat.link_cfg) begin
                     state_in = ST_IDLE;
                  end else if (stat.tx_full) begin
                     cmd.drop_inc = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.tx_write = 1'b1;
                     state_in     = ST_PUMP;
                  end
               end
               ubbp_pkg::FUNC_GET: begin
                  if (!stat.rx_empty) begin
                     cmd.rx_read = 1'b1;
                     state_in    = ST_GET;
                  end else if (stat.out_free) begin
                     cmd.emit_get = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               ubbp_pkg::FUNC_HOST_BYTE: begin
                  cmd.rx_write = !stat.rx_full;
                  state_in     = ST_PUMP;
               end
               ubbp_pkg::FUNC_IN_DONE: begin
                  cmd.clr_flight = 1'b1;
                  state_in       = ST_PUMP;
               end
               ubbp_pkg::FUNC_BUS_RESET: begin
                  cmd.bus_reset = 1'b1;
                  state_in      = ST_PUMP;
               end
               ubbp_pkg::FUNC_SET_CFG: begin
                  cmd.set_cfg = 1'b1;
                  state_in    = ST_PUMP;
               end
               ubbp_pkg::FUNC_POLL: begin
                  state_in = ST_PUMP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_GET: begin
            if (stat.out_free) begin
               cmd.emit_get = 1'b1;
               cmd.get_hit  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PUMP: begin
            priority if (stat.in_flight || !stat.link_cfg) begin
               state_in = ST_IDLE;
            end else if (!stat.tx_empty) begin
               cmd.tx_read = 1'b1;
               state_in    = ST_EMIT;
            end else if (!stat.zlp_owed) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_zlp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_byte = 1'b1;
               if (stat.pkt_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> (state_ff == ST_IDLE))
      else $error("request ready outside idle");

   a_bytes_need_link: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_byte || cmd.emit_zlp) |-> (stat.link_cfg && !stat.in_flight))
      else $error("packet emitted while unconfigured or IN busy");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (state_ff == ST_EXEC && !req_ready_ff))
      else $error("accepted request not executed next cycle");

endmodule

### sim/usb_bulk_byte_pipe_packetizer_core_test.sv
// Self-checking bench for usb_bulk_byte_pipe_packetizer_core: a mirror of both rings
// and the IN packet logic predicts every rsp transfer, which is checked field by field.
// Depends on ubbp_pkg and the RTL under src/.
`timescale 1ns / 1ps

module usb_bulk_byte_pipe_packetizer_core_test;
   import ubbp_pkg::*;

   localparam int TX_DEPTH    = TX_DEPTH_DEF;
   localparam int RX_DEPTH    = RX_DEPTH_DEF;
   localparam int PKT_BYTES   = PACKET_BYTES_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;
   localparam int RANDOM_REQS = 130;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   usb_bulk_byte_pipe_packetizer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // stimulus and expectations
   req_type queued_reqs[$];
   bit      queued_drain[$];   // sender waits for all owed results before this one
   rsp_type owed_rsps[$];

   // mirror of the pipe state
   logic [7:0]  tx_mirror [0:TX_DEPTH-1];
   logic [7:0]  rx_mirror [0:RX_DEPTH-1];
   int unsigned tx_wr = 0, tx_rd = 0, rx_wr = 0, rx_rd = 0;
   bit          flight = 1'b0, zlp_due = 1'b0, linked = 1'b0;
   logic [31:0] drops = '0, resets = '0;

   int  error_count = 0;
   int  rsp_seen = 0;
   int  accepted = 0;
   int  cycle_count = 0;
   logic req_fired = 1'b0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  calm;
   bit  quiet;

   assign calm  = queued_reqs.size() < 60;
   assign quiet = ((accepted / 40) % 3) == 2;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   task automatic log_mismatch(input string msg);
      if (error_count < 50)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic void push_rsp(input logic [1:0] kind, input logic [7:0] data,
                                    input logic got, input logic last);
      rsp_type r;
      r.kind           = kind;
      r.data_byte      = data;
      r.got_byte       = got;
      r.last_in_packet = last;
      r.dropped_count  = drops;
      r.reset_count    = resets;
      owed_rsps.push_back(r);
   endfunction

   // IN endpoint: up to one packet when configured and idle, ZLP after a full one
   function automatic void send_packet();
      logic [7:0] pkt[$];
      if (flight || !linked) return;
      while (pkt.size() < PKT_BYTES && tx_rd != tx_wr) begin
         pkt.push_back(tx_mirror[tx_rd]);
         tx_rd = (tx_rd + 1 == TX_DEPTH) ? 0 : tx_rd + 1;
      end
      if (pkt.size() == 0) begin
         if (zlp_due) begin
            zlp_due = 1'b0;
            push_rsp(KIND_ZLP, 8'h00, 1'b0, 1'b1);
            flight = 1'b1;
         end
         return;
      end
      foreach (pkt[i]) push_rsp(KIND_BYTE, pkt[i], 1'b0, i == pkt.size() - 1);
      zlp_due = (pkt.size() == PKT_BYTES);
      flight  = 1'b1;
   endfunction

   function automatic void predict_pipe(input req_type r);
      int unsigned nxt;
      case (r.func)
         FUNC_PUT: begin
            if (linked) begin
               nxt = (tx_wr + 1 == TX_DEPTH) ? 0 : tx_wr + 1;
               if (nxt == tx_rd) begin
                  drops = drops + 32'd1;
               end else begin
                  tx_mirror[tx_wr] = r.byte_value;
                  tx_wr = nxt;
                  send_packet();
               end
            end
         end
         FUNC_GET: begin
            if (rx_rd == rx_wr) begin
               push_rsp(KIND_GET, 8'h00, 1'b0, 1'b0);
            end else begin
               push_rsp(KIND_GET, rx_mirror[rx_rd], 1'b1, 1'b0);
               rx_rd = (rx_rd + 1 == RX_DEPTH) ? 0 : rx_rd + 1;
            end
         end
         FUNC_HOST_BYTE: begin
            nxt = (rx_wr + 1 == RX_DEPTH) ? 0 : rx_wr + 1;
            if (nxt != rx_rd) begin
               rx_mirror[rx_wr] = r.byte_value;
               rx_wr = nxt;
            end
            send_packet();
         end
         FUNC_IN_DONE: begin
            flight = 1'b0;
            send_packet();
         end
         FUNC_BUS_RESET: begin
            resets  = resets + 32'd1;
            linked  = 1'b0;
            flight  = 1'b0;
            zlp_due = 1'b0;
            tx_wr   = 0;
            tx_rd   = 0;
            rx_wr   = 0;
            rx_rd   = 0;
            send_packet();
         end
         FUNC_SET_CFG: begin
            linked = r.config_flag;
            send_packet();
         end
         FUNC_POLL: send_packet();
         default: ;
      endcase
   endfunction

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (owed_rsps.size() == 0) begin
         log_mismatch($sformatf("transfer %0d not expected: kind %0d data %02h",
                                rsp_seen, got.kind, got.data_byte));
         rsp_seen++;
         return;
      end
      want = owed_rsps.pop_front();
      if (got.kind !== want.kind)
         log_mismatch($sformatf("transfer %0d kind %0d, want %0d",
                                rsp_seen, got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
         log_mismatch($sformatf("transfer %0d data_byte %02h, want %02h",
                                rsp_seen, got.data_byte, want.data_byte));
      if (got.got_byte !== want.got_byte)
         log_mismatch($sformatf("transfer %0d got_byte %0b, want %0b",
                                rsp_seen, got.got_byte, want.got_byte));
      if (got.last_in_packet !== want.last_in_packet)
         log_mismatch($sformatf("transfer %0d last_in_packet %0b, want %0b",
                                rsp_seen, got.last_in_packet, want.last_in_packet));
      if (got.dropped_count !== want.dropped_count)
         log_mismatch($sformatf("transfer %0d dropped_count %0d, want %0d",
                                rsp_seen, got.dropped_count, want.dropped_count));
      if (got.reset_count !== want.reset_count)
         log_mismatch($sformatf("transfer %0d reset_count %0d, want %0d",
                                rsp_seen, got.reset_count, want.reset_count));
      rsp_seen++;
   endtask

   task automatic add_req(input logic [2:0] f, input logic [7:0] b, input logic c,
                          input bit drain);
      req_type r;
      r.func        = f;
      r.byte_value  = b;
      r.config_flag = c;
      queued_reqs.push_back(r);
      queued_drain.push_back(drain);
   endtask

   function automatic logic [7:0] rb();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rf();
      return 1'($urandom_range(0, 1));
   endfunction

   // monitor: rsp is checked before the req of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
         if (req_valid && req_ready) begin
            predict_pipe(req_data);
            accepted <= accepted + 1;
         end
         req_fired <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("usb_bulk_byte_pipe_packetizer_core_test: errors");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      logic offer;
      offer = req_valid && !req_fired;
      if (reset) begin
         offer = 1'b0;
      end else if (!offer) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (queued_reqs.size() > 0 &&
                      (!queued_drain[0] || owed_rsps.size() == 0)) begin
            req_data <= queued_reqs.pop_front();
            void'(queued_drain.pop_front());
            offer = 1'b1;
            if (!calm && !quiet && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 14);
         end
      end
      req_valid <= offer;
   end

   // result receiver; one long hold-off fills the block and blocks req
   always @(negedge clock) begin
      logic take;
      take = 1'b1;
      if (hold_left > 0) begin
         hold_left--;
         take = 1'b0;
      end else if (!hold_done && rsp_valid && accepted >= 30) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         take = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         take = 1'b0;
      end
      rsp_ready <= take;
   end

   initial begin
      int made;
      int sel;
      int n;
      int waited;
      bit drain_next;

      // link down: puts ignored, gets empty, unused code
      add_req(FUNC_PUT, 8'h00, 1'b1, 1'b0);
      add_req(FUNC_GET, 8'hFF, 1'b1, 1'b0);
      add_req(FUNC_HOST_BYTE, 8'hFF, 1'b0, 1'b0);
      add_req(FUNC_IN_DONE, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_POLL, 8'hFF, 1'b1, 1'b0);
      add_req(FUNC_UNUSED, 8'hFF, 1'b1, 1'b0);
      add_req(FUNC_SET_CFG, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_PUT, 8'h55, 1'b0, 1'b0);
      add_req(FUNC_BUS_RESET, 8'hAA, 1'b1, 1'b0);
      add_req(FUNC_GET, 8'h00, 1'b0, 1'b0);
      // configured: single-byte packets, in-flight hold, rx path
      add_req(FUNC_SET_CFG, 8'hFF, 1'b1, 1'b0);
      add_req(FUNC_PUT, 8'hFF, 1'b0, 1'b0);
      add_req(FUNC_PUT, 8'h00, 1'b1, 1'b0);
      add_req(FUNC_POLL, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_IN_DONE, 8'hFF, 1'b1, 1'b0);
      add_req(FUNC_IN_DONE, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_HOST_BYTE, 8'h00, 1'b1, 1'b0);
      add_req(FUNC_HOST_BYTE, 8'hA5, 1'b0, 1'b0);
      add_req(FUNC_GET, 8'h00, 1'b1, 1'b0);
      add_req(FUNC_GET, 8'hFF, 1'b0, 1'b0);
      add_req(FUNC_GET, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_SET_CFG, 8'h00, 1'b0, 1'b0);
      add_req(FUNC_PUT, 8'h77, 1'b1, 1'b0);
      add_req(FUNC_SET_CFG, 8'h00, 1'b1, 1'b0);
      add_req(FUNC_UNUSED, 8'h00, 1'b0, 1'b0);

      // exactly one full packet, then its ZLP
      add_req(FUNC_PUT, rb(), rf(), 1'b0);
      repeat (PKT_BYTES) add_req(FUNC_PUT, rb(), rf(), 1'b0);
      add_req(FUNC_IN_DONE, rb(), rf(), 1'b0);
      add_req(FUNC_IN_DONE, rb(), rf(), 1'b0);
      add_req(FUNC_IN_DONE, rb(), rf(), 1'b0);

      // bus reset with bytes queued, a packet in flight and a ZLP owed
      add_req(FUNC_PUT, rb(), rf(), 1'b1);
      repeat (PKT_BYTES + 4) add_req(FUNC_PUT, rb(), rf(), 1'b0);
      add_req(FUNC_IN_DONE, rb(), rf(), 1'b0);
      add_req(FUNC_BUS_RESET, rb(), rf(), 1'b0);
      add_req(FUNC_POLL, rb(), rf(), 1'b0);
      add_req(FUNC_SET_CFG, rb(), 1'b1, 1'b0);
      add_req(FUNC_PUT, rb(), rf(), 1'b0);

      made = 0;
      drain_next = 1'b0;
      while (made < RANDOM_REQS) begin
         if ((made % 100) > 90) drain_next = 1'b1;
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            repeat (n) begin
               add_req(FUNC_PUT, rb(), rf(), drain_next);
               drain_next = 1'b0;
            end
            made += n;
         end else if (sel < 42) begin
            add_req(FUNC_GET, rb(), rf(), drain_next);
            made++;
         end else if (sel < 54) begin
            add_req(FUNC_HOST_BYTE, rb(), rf(), drain_next);
            made++;
         end else if (sel < 70) begin
            add_req(FUNC_IN_DONE, rb(), rf(), drain_next);
            made++;
         end else if (sel < 77) begin
            add_req(FUNC_POLL, rb(), rf(), drain_next);
            made++;
         end else if (sel < 85) begin
            add_req(FUNC_SET_CFG, rb(), logic'($urandom_range(0, 4) != 0), drain_next);
            made++;
         end else if (sel < 89) begin
            add_req(FUNC_BUS_RESET, rb(), rf(), drain_next);
            add_req(FUNC_SET_CFG, rb(), 1'b1, 1'b0);
            made += 2;
         end else if (sel < 92) begin
            add_req(FUNC_UNUSED, rb(), rf(), drain_next);
            made++;
         end else begin
            n = $urandom_range(3, 10);
            repeat (n) begin
               add_req(FUNC_HOST_BYTE, rb(), rf(), drain_next);
               drain_next = 1'b0;
            end
            repeat (n) add_req(FUNC_GET, rb(), rf(), 1'b0);
            made += 2 * n;
         end
         drain_next = 1'b0;
      end

      while (queued_reqs.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (owed_rsps.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (owed_rsps.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", owed_rsps.size()));
      if (error_count == 0) begin
         $display("usb_bulk_byte_pipe_packetizer_core_test: clean");
      end else begin
         $display("usb_bulk_byte_pipe_packetizer_core_test: errors");
      end
      $finish;
   end

endmodule
